@@ rtl/core/pidfx_pkg.sv @@
// Package for the fixed-point PID controller.
// Widths, queue depths, register index codes and the shared structs.
// No dependencies.
package pidfx_pkg;

   localparam int FRAC_BITS = 12;

   localparam int SMP_W  = 16;
   localparam int ERR_W  = SMP_W + 1;
   localparam int DIFF_W = ERR_W + 1;
   localparam int INT_W  = 25;
   localparam int SUM_W  = INT_W + 1;
   localparam int GAIN_W = 24;
   localparam int DRV_W  = 16;
   localparam int CSR_W  = 25;
   localparam int CSR_IDX_W = 3;

   localparam int PROD_P_W = GAIN_W + ERR_W;
   localparam int PROD_I_W = GAIN_W + INT_W;
   localparam int PROD_D_W = GAIN_W + DIFF_W;
   localparam int ACC_W    = PROD_I_W + 2;
   localparam int RND_W    = ACC_W + 1;
   localparam int Q_W      = RND_W - FRAC_BITS;
   localparam int Y_W      = ACC_W + 1;

   localparam logic [RND_W-1:0] ROUND_HALF = RND_W'((64'(1) << FRAC_BITS) >> 1);

   localparam int MQ_DEPTH = 4;
   localparam int MQ_PTR_W = $clog2(MQ_DEPTH);
   localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
   localparam int OQ_DEPTH = 8;
   localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_INT_UPPER,
      CSR_INT_LOWER,
      CSR_DRIVE_UPPER,
      CSR_DRIVE_LOWER
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic signed [INT_W-1:0]  integral_upper;
      logic signed [INT_W-1:0]  integral_lower;
      logic signed [DRV_W-1:0]  drive_upper;
      logic signed [DRV_W-1:0]  drive_lower;
   } cfg_type;

   // one classified sample handed from front to back
   typedef struct packed {
      logic signed [ERR_W-1:0]  err;
      logic signed [DIFF_W-1:0] diff;
      logic signed [INT_W-1:0]  integ;
   } work_type;

endpackage

@@ rtl/core/pidfx_front.sv @@
// Front end: takes a sample, forms error and difference, updates the
// clamped integral and hands the result on. Depends on pidfx_pkg.
module pidfx_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic                                  clear,
   input  logic signed [pidfx_pkg::SMP_W-1:0]    setpoint,
   input  logic signed [pidfx_pkg::SMP_W-1:0]    measured,
   input  pidfx_pkg::cfg_type                    cfg,
   output pidfx_pkg::work_type                   work
);

   logic signed [pidfx_pkg::ERR_W-1:0]  last_error_ff;
   logic signed [pidfx_pkg::INT_W-1:0]  error_sum_ff;
   logic signed [pidfx_pkg::ERR_W-1:0]  err;
   logic signed [pidfx_pkg::DIFF_W-1:0] diff;
   logic signed [pidfx_pkg::SUM_W-1:0]  sum_raw;
   logic signed [pidfx_pkg::SUM_W-1:0]  lim_hi;
   logic signed [pidfx_pkg::SUM_W-1:0]  lim_lo;
   logic signed [pidfx_pkg::INT_W-1:0]  error_sum_in;

   always_comb begin
      err  = pidfx_pkg::ERR_W'($signed(setpoint)) - pidfx_pkg::ERR_W'($signed(measured));
      diff = pidfx_pkg::DIFF_W'(err) - pidfx_pkg::DIFF_W'(last_error_ff);
      sum_raw = pidfx_pkg::SUM_W'(error_sum_ff) + pidfx_pkg::SUM_W'(err);
      lim_hi  = pidfx_pkg::SUM_W'($signed(cfg.integral_upper));
      lim_lo  = pidfx_pkg::SUM_W'($signed(cfg.integral_lower));
      // upper bound wins when the limits are crossed
      priority if (sum_raw > lim_hi) begin
         error_sum_in = cfg.integral_upper;
      end else if (sum_raw < lim_lo) begin
         error_sum_in = cfg.integral_lower;
      end else begin
         error_sum_in = pidfx_pkg::INT_W'(sum_raw);
      end
      work.err   = err;
      work.diff  = diff;
      work.integ = error_sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else if (accept) begin
         last_error_ff <= err;
         error_sum_ff  <= error_sum_in;
      end
   end

endmodule

@@ rtl/core/pidfx_queue.sv @@
// Short queue of classified samples between front and back end.
// Depends on pidfx_pkg.
module pidfx_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pidfx_pkg::work_type  entry_in,
   output logic                 full,
   input  logic                 pop,
   output pidfx_pkg::work_type  entry_out,
   output logic                 empty
);

   pidfx_pkg::work_type                mem_ff [pidfx_pkg::MQ_DEPTH];
   logic [pidfx_pkg::MQ_PTR_W-1:0]     wr_ptr_ff;
   logic [pidfx_pkg::MQ_PTR_W-1:0]     rd_ptr_ff;
   logic [pidfx_pkg::MQ_CNT_W-1:0]     count_ff;
   logic                               do_push;
   logic                               do_pop;

   assign full      = (count_ff == pidfx_pkg::MQ_CNT_W'(pidfx_pkg::MQ_DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign entry_out = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/core/pidfx_back.sv @@
// Back end: four-stage datapath (gain products, sum, round, clamp) feeding
// a result queue. Issue is credit based on the result queue's free space.
// Depends on pidfx_pkg.
module pidfx_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 work_avail,
   input  pidfx_pkg::work_type                  work,
   output logic                                 work_take,
   input  pidfx_pkg::cfg_type                   cfg,
   output logic                                 out_empty,
   input  logic                                 out_pop,
   output logic signed [pidfx_pkg::DRV_W-1:0]   out_drive
);

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   logic signed [pidfx_pkg::PROD_P_W-1:0] prod_p_ff, prod_p_in;
   logic signed [pidfx_pkg::PROD_I_W-1:0] prod_i_ff, prod_i_in;
   logic signed [pidfx_pkg::PROD_D_W-1:0] prod_d_ff, prod_d_in;
   logic signed [pidfx_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [pidfx_pkg::ACC_W-1:0]           mag;
   logic [pidfx_pkg::RND_W-1:0]           rnd;
   logic [pidfx_pkg::Q_W-1:0]             quot_ff, quot_in;
   logic                                  neg_ff;
   logic signed [pidfx_pkg::Y_W-1:0]      y_val;
   logic signed [pidfx_pkg::Y_W-1:0]      y_hi;
   logic signed [pidfx_pkg::Y_W-1:0]      y_lo;
   logic signed [pidfx_pkg::DRV_W-1:0]    drive_ff, drive_in;

   logic signed [pidfx_pkg::DRV_W-1:0]    oq_mem_ff [pidfx_pkg::OQ_DEPTH];
   logic [pidfx_pkg::OQ_PTR_W-1:0]        oq_wr_ff;
   logic [pidfx_pkg::OQ_PTR_W-1:0]        oq_rd_ff;
   logic [pidfx_pkg::OQ_CNT_W-1:0]        oq_count_ff;
   logic [pidfx_pkg::OQ_CNT_W-1:0]        in_flight;
   logic [pidfx_pkg::OQ_CNT_W:0]          committed;
   logic                                  oq_pop;

   assign in_flight = pidfx_pkg::OQ_CNT_W'(v1_ff) + pidfx_pkg::OQ_CNT_W'(v2_ff)
                    + pidfx_pkg::OQ_CNT_W'(v3_ff) + pidfx_pkg::OQ_CNT_W'(v4_ff);
   assign committed = (pidfx_pkg::OQ_CNT_W+1)'(in_flight)
                    + (pidfx_pkg::OQ_CNT_W+1)'(oq_count_ff);
   // a beat is only issued if a result slot is guaranteed
   assign work_take = work_avail
                    && (committed < (pidfx_pkg::OQ_CNT_W+1)'(pidfx_pkg::OQ_DEPTH));

   always_comb begin
      prod_p_in = $signed(cfg.gain_p) * $signed(work.err);
      prod_i_in = $signed(cfg.gain_i) * $signed(work.integ);
      prod_d_in = $signed(cfg.gain_d) * $signed(work.diff);

      acc_in = pidfx_pkg::ACC_W'(prod_p_ff) + pidfx_pkg::ACC_W'(prod_i_ff)
             + pidfx_pkg::ACC_W'(prod_d_ff);

      // round half away from zero on the magnitude
      mag     = acc_ff[pidfx_pkg::ACC_W-1] ? pidfx_pkg::ACC_W'(-acc_ff)
                                           : pidfx_pkg::ACC_W'(acc_ff);
      rnd     = pidfx_pkg::RND_W'(mag) + pidfx_pkg::ROUND_HALF;
      quot_in = pidfx_pkg::Q_W'(rnd >> pidfx_pkg::FRAC_BITS);

      y_val = pidfx_pkg::Y_W'(quot_ff);
      if (neg_ff) y_val = -y_val;
      y_hi = pidfx_pkg::Y_W'($signed(cfg.drive_upper));
      y_lo = pidfx_pkg::Y_W'($signed(cfg.drive_lower));
      priority if (y_val > y_hi) begin
         drive_in = cfg.drive_upper;
      end else if (y_val < y_lo) begin
         drive_in = cfg.drive_lower;
      end else begin
         drive_in = pidfx_pkg::DRV_W'(y_val);
      end
   end

   always_ff @(posedge clock) begin
      prod_p_ff <= prod_p_in;
      prod_i_ff <= prod_i_in;
      prod_d_ff <= prod_d_in;
      acc_ff    <= acc_in;
      quot_ff   <= quot_in;
      neg_ff    <= acc_ff[pidfx_pkg::ACC_W-1];
      drive_ff  <= drive_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= work_take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // result queue
   assign out_empty = (oq_count_ff == '0);
   assign oq_pop    = out_pop && !out_empty;
   assign out_drive = oq_mem_ff[oq_rd_ff];

   always_ff @(posedge clock) begin
      if (v4_ff) begin
         oq_mem_ff[oq_wr_ff] <= drive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         if (v4_ff)  oq_wr_ff <= oq_wr_ff + 1'b1;
         if (oq_pop) oq_rd_ff <= oq_rd_ff + 1'b1;
         if (v4_ff && !oq_pop) begin
            oq_count_ff <= oq_count_ff + 1'b1;
         end else if (oq_pop && !v4_ff) begin
            oq_count_ff <= oq_count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/core/pid_controller_fixed_point_top.sv @@
// Top level of the fixed-point PID controller: register file, front end,
// work queue and back end. Depends on pidfx_pkg, pidfx_front, pidfx_queue,
// pidfx_back.
//
// Positional PID with a clamped integral. Takes one sample (setpoint,
// measured) per clock while req_full is low and returns one drive beat per
// sample, in order. A sample whose result queue slot is free passes the
// front end and work queue, then four back-end stages (gain products, sum,
// round, clamp), and leaves on rsp_*. The integral and last error live in
// the front end and are registered on each accepted sample, so samples
// follow back to back; a four-beat work queue and an eight-beat result
// queue absorb stalls on either side. A write to any of the seven registers
// clears the integral and last error; write only while no sample is in flight.
module pid_controller_fixed_point_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [pidfx_pkg::SMP_W-1:0]   req_setpoint,
   input  logic signed [pidfx_pkg::SMP_W-1:0]   req_measured,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic signed [pidfx_pkg::DRV_W-1:0]   rsp_drive,
   input  logic                                 csr_we,
   input  logic [pidfx_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pidfx_pkg::CSR_W-1:0]          csr_wdata
);

   pidfx_pkg::cfg_type  cfg_ff;
   pidfx_pkg::work_type front_work;
   pidfx_pkg::work_type back_work;
   logic                cfg_clear;
   logic                accept;
   logic                mq_empty;
   logic                back_take;

   assign accept = req_push && !req_full;

   always_comb begin
      unique case (pidfx_pkg::csr_index_type'(csr_index))
         pidfx_pkg::CSR_GAIN_P,
         pidfx_pkg::CSR_GAIN_I,
         pidfx_pkg::CSR_GAIN_D,
         pidfx_pkg::CSR_INT_UPPER,
         pidfx_pkg::CSR_INT_LOWER,
         pidfx_pkg::CSR_DRIVE_UPPER,
         pidfx_pkg::CSR_DRIVE_LOWER: cfg_clear = csr_we;
         default:                    cfg_clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (pidfx_pkg::csr_index_type'(csr_index))
            pidfx_pkg::CSR_GAIN_P: begin
               cfg_ff.gain_p <= csr_wdata[pidfx_pkg::GAIN_W-1:0];
            end
            pidfx_pkg::CSR_GAIN_I: begin
               cfg_ff.gain_i <= csr_wdata[pidfx_pkg::GAIN_W-1:0];
            end
            pidfx_pkg::CSR_GAIN_D: begin
               cfg_ff.gain_d <= csr_wdata[pidfx_pkg::GAIN_W-1:0];
            end
            pidfx_pkg::CSR_INT_UPPER: begin
               cfg_ff.integral_upper <= csr_wdata[pidfx_pkg::INT_W-1:0];
            end
            pidfx_pkg::CSR_INT_LOWER: begin
               cfg_ff.integral_lower <= csr_wdata[pidfx_pkg::INT_W-1:0];
            end
            pidfx_pkg::CSR_DRIVE_UPPER: begin
               cfg_ff.drive_upper <= csr_wdata[pidfx_pkg::DRV_W-1:0];
            end
            pidfx_pkg::CSR_DRIVE_LOWER: begin
               cfg_ff.drive_lower <= csr_wdata[pidfx_pkg::DRV_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   pidfx_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .clear    (cfg_clear),
      .setpoint (req_setpoint),
      .measured (req_measured),
      .cfg      (cfg_ff),
      .work     (front_work)
   );

   pidfx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .entry_in  (front_work),
      .full      (req_full),
      .pop       (back_take),
      .entry_out (back_work),
      .empty     (mq_empty)
   );

   pidfx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work_avail (!mq_empty),
      .work       (back_work),
      .work_take  (back_take),
      .cfg        (cfg_ff),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_drive  (rsp_drive)
   );

endmodule

@@ sim/pid_controller_fixed_point_top_test.sv @@
// Self-checking bench for pid_controller_fixed_point_top: bursty samples in,
// stalled drive beats out, each beat checked against a PID predictor.
// Depends on pidfx_pkg and the RTL of the block.
`timescale 1ns / 1ps

module pid_controller_fixed_point_top_test;
   import pidfx_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;  // past the register list

   localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};
   localparam logic signed [INT_W-1:0]  INT_MAX  = {1'b0, {(INT_W-1){1'b1}}};
   localparam logic signed [INT_W-1:0]  INT_MIN  = {1'b1, {(INT_W-1){1'b0}}};
   localparam logic signed [DRV_W-1:0]  DRV_MAX  = {1'b0, {(DRV_W-1){1'b1}}};
   localparam logic signed [DRV_W-1:0]  DRV_MIN  = {1'b1, {(DRV_W-1){1'b0}}};
   localparam logic signed [SMP_W-1:0]  SMP_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic signed [SMP_W-1:0]  SMP_MIN  = {1'b1, {(SMP_W-1){1'b0}}};

   typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_RARELY, POP_PATTERN} pop_style_t;
   typedef enum int {SMP_WIDE, SMP_NEAR, SMP_EDGE, SMP_MIXED} sample_style_t;

   class drive_scoreboard;
      cfg_type                  regs;
      logic signed [ERR_W-1:0]  last_err;
      logic signed [INT_W-1:0]  err_sum;
      logic signed [DRV_W-1:0]  expected_drive[$];
      int                       mismatches;

      function new();
         regs = '0;
         last_err = '0;
         err_sum = '0;
         mismatches = 0;
      endfunction

      function automatic longint clamp_upper_first(longint v, longint lo, longint hi);
         if (v > hi)
            return hi;
         if (v < lo)
            return lo;
         return v;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            CSR_GAIN_P:      regs.gain_p = data[GAIN_W-1:0];
            CSR_GAIN_I:      regs.gain_i = data[GAIN_W-1:0];
            CSR_GAIN_D:      regs.gain_d = data[GAIN_W-1:0];
            CSR_INT_UPPER:   regs.integral_upper = data[INT_W-1:0];
            CSR_INT_LOWER:   regs.integral_lower = data[INT_W-1:0];
            CSR_DRIVE_UPPER: regs.drive_upper = data[DRV_W-1:0];
            CSR_DRIVE_LOWER: regs.drive_lower = data[DRV_W-1:0];
            default:         return;
         endcase
         last_err = '0;
         err_sum = '0;
      endfunction

      function void note_sample(logic signed [SMP_W-1:0] sp, logic signed [SMP_W-1:0] ms);
         longint e, d, s, acc, mag, q, y;
         longint half;
         half = (longint'(1) << FRAC_BITS) >> 1;
         e = longint'(sp) - longint'(ms);
         d = e - longint'(last_err);
         s = clamp_upper_first(longint'(err_sum) + e, longint'(regs.integral_lower),
                               longint'(regs.integral_upper));
         err_sum = INT_W'(s);
         acc = longint'(regs.gain_p) * e + longint'(regs.gain_i) * longint'(err_sum)
               + longint'(regs.gain_d) * d;
         // round half away from zero on the magnitude
         mag = (acc > 0) ? acc : -acc;
         q = (mag + half) >> FRAC_BITS;
         y = (acc > 0) ? q : -q;
         y = clamp_upper_first(y, longint'(regs.drive_lower), longint'(regs.drive_upper));
         expected_drive.push_back(DRV_W'(y));
         last_err = ERR_W'(e);
      endfunction

      function void check_drive(logic signed [DRV_W-1:0] actual);
         logic signed [DRV_W-1:0] exp_drive;
         if (expected_drive.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected drive beat %0d", $realtime, actual);
            return;
         end
         exp_drive = expected_drive.pop_front();
         if (actual !== exp_drive) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: drive mismatch, expected %0d got %0d",
                        $realtime, exp_drive, actual);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_push;
   logic                      req_full;
   logic signed [SMP_W-1:0]   req_setpoint;
   logic signed [SMP_W-1:0]   req_measured;
   logic                      rsp_empty;
   logic                      rsp_pop;
   logic signed [DRV_W-1:0]   rsp_drive;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_W-1:0]          csr_wdata;

   drive_scoreboard sb;
   pop_style_t      pop_style;
   int              cycle_count = 0;

   pid_controller_fixed_point_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pid_controller_fixed_point_top_test failed");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      case (pop_style)
         POP_ALWAYS:  rsp_pop <= 1'b1;
         POP_MOSTLY:  rsp_pop <= ($urandom_range(0, 3) != 0);
         POP_RARELY:  rsp_pop <= ($urandom_range(0, 3) == 0);
         default:     rsp_pop <= ((cycle_count % 23) < 9);
      endcase
   end

   // every beat is observed on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            sb.write_reg(csr_index, csr_wdata);
         if (req_push && !req_full)
            sb.note_sample(req_setpoint, req_measured);
         if (rsp_pop && !rsp_empty)
            sb.check_drive(rsp_drive);
      end
   end

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic push_sample(logic signed [SMP_W-1:0] sp, logic signed [SMP_W-1:0] ms);
      req_push <= 1'b1;
      req_setpoint <= sp;
      req_measured <= ms;
      do @(posedge clock); while (req_full);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   function automatic logic [CSR_W-1:0] with_junk(logic [CSR_W-1:0] v, int w, bit junk);
      logic [CSR_W-1:0] keep;
      keep = (CSR_W'(1) << w) - CSR_W'(1);
      return junk ? ((v & keep) | (CSR_W'($urandom) & ~keep)) : v;
   endfunction

   task automatic load_regs(cfg_type c, bit junk);
      write_csr(CSR_GAIN_P, with_junk(CSR_W'(c.gain_p), GAIN_W, junk));
      write_csr(CSR_GAIN_I, with_junk(CSR_W'(c.gain_i), GAIN_W, junk));
      write_csr(CSR_GAIN_D, with_junk(CSR_W'(c.gain_d), GAIN_W, junk));
      write_csr(CSR_INT_UPPER, CSR_W'(c.integral_upper));
      write_csr(CSR_INT_LOWER, CSR_W'(c.integral_lower));
      write_csr(CSR_DRIVE_UPPER, with_junk(CSR_W'(c.drive_upper), DRV_W, junk));
      write_csr(CSR_DRIVE_LOWER, with_junk(CSR_W'(c.drive_lower), DRV_W, junk));
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (sb.expected_drive.size() != 0)
         @(negedge clock);
      @(posedge clock);
   endtask

   function automatic logic signed [SMP_W-1:0] pick_sample(sample_style_t s);
      sample_style_t st;
      st = (s == SMP_MIXED) ? sample_style_t'($urandom_range(0, 2)) : s;
      case (st)
         SMP_NEAR: return SMP_W'(int'($urandom_range(0, 600)) - 300);
         SMP_EDGE:
            case ($urandom_range(0, 4))
               0:       return SMP_MAX;
               1:       return SMP_MIN;
               2:       return '0;
               3:       return '1;
               default: return SMP_W'(1);
            endcase
         default:  return SMP_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0:       return GAIN_W'(int'($urandom_range(0, 16384)) - 8192);
         1:       return GAIN_W'($urandom);
         2:       return $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
         default: return GAIN_W'(int'($urandom_range(0, 65536)) - 32768);
      endcase
   endfunction

   function automatic cfg_type make_cfg();
      cfg_type c;
      logic signed [INT_W-1:0] ia, ib;
      logic signed [DRV_W-1:0] da, db;
      bit crossed;
      c.gain_p = pick_gain();
      c.gain_i = pick_gain();
      c.gain_d = pick_gain();
      ia = INT_W'($urandom);
      ib = INT_W'($urandom);
      case ($urandom_range(0, 2))
         0: begin
            ia = INT_W'(int'($urandom_range(0, 4000)) - 2000);
            ib = INT_W'(int'($urandom_range(0, 4000)) - 2000);
         end
         1: begin
            ia = INT_MAX;
            ib = INT_MIN;
         end
         default: ;
      endcase
      crossed = ($urandom_range(0, 4) == 0);
      c.integral_upper = ((ia > ib) != crossed) ? ia : ib;
      c.integral_lower = ((ia > ib) != crossed) ? ib : ia;
      da = DRV_W'($urandom);
      db = DRV_W'($urandom);
      case ($urandom_range(0, 2))
         0: begin
            da = DRV_W'(int'($urandom_range(0, 4000)) - 2000);
            db = DRV_W'(int'($urandom_range(0, 4000)) - 2000);
         end
         1: begin
            da = DRV_MAX;
            db = DRV_MIN;
         end
         default: ;
      endcase
      crossed = ($urandom_range(0, 4) == 0);
      c.drive_upper = ((da > db) != crossed) ? da : db;
      c.drive_lower = ((da > db) != crossed) ? db : da;
      return c;
   endfunction

   task automatic run_samples(int count, sample_style_t style, bit bursty);
      int left, burst;
      left = count;
      while (left > 0) begin
         burst = bursty ? $urandom_range(1, 12) : left;
         if (burst > left)
            burst = left;
         left -= burst;
         repeat (burst)
            push_sample(pick_sample(style), pick_sample(style));
         if (bursty && left > 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
      req_push <= 1'b0;
   endtask

   initial begin
      cfg_type c;
      int      sent, n;
      sb = new();
      reset = 1'b1;
      req_push = 1'b0;
      req_setpoint = '0;
      req_measured = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      pop_style = POP_ALWAYS;
      rsp_pop = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: zero limits hold the drive at zero
      push_sample(SMP_MAX, SMP_MIN);
      push_sample(SMP_MIN, SMP_MAX);
      push_sample(16'sd1234, -16'sd77);
      req_push <= 1'b0;
      drain();

      // half a unit of gain: ties round away from zero
      c = '0;
      c.gain_p = GAIN_W'(1 << (FRAC_BITS - 1));
      c.integral_upper = INT_W'(1000);
      c.integral_lower = -INT_W'(1000);
      c.drive_upper = DRV_MAX;
      c.drive_lower = DRV_MIN;
      load_regs(c, 1'b0);
      push_sample(16'sd1, 16'sd0);
      push_sample(16'sd0, 16'sd1);
      push_sample(16'sd3, 16'sd0);
      push_sample(16'sd0, 16'sd3);
      push_sample(16'sd0, 16'sd0);
      req_push <= 1'b0;
      drain();

      // extreme gains, limits and errors
      c.gain_p = GAIN_MIN;
      c.gain_i = GAIN_MAX;
      c.gain_d = GAIN_MIN;
      c.integral_upper = INT_MAX;
      c.integral_lower = INT_MIN;
      load_regs(c, 1'b1);
      push_sample(SMP_MAX, SMP_MIN);
      push_sample(SMP_MAX, SMP_MIN);
      push_sample(SMP_MIN, SMP_MAX);
      push_sample(16'sd0, 16'sd0);
      push_sample(-16'sd1, 16'sd0);
      req_push <= 1'b0;
      drain();

      // a write past the register list must leave integral and last error alone
      write_csr(CSR_SPARE, CSR_W'($urandom));
      csr_we <= 1'b0;
      push_sample(16'sd100, 16'sd0);
      push_sample(16'sd100, 16'sd0);
      req_push <= 1'b0;
      drain();

      // crossed limits: upper test wins
      c.gain_p = GAIN_W'(1 << FRAC_BITS);
      c.gain_i = GAIN_W'(1 << FRAC_BITS);
      c.gain_d = '0;
      c.integral_upper = -INT_W'(50);
      c.integral_lower = INT_W'(50);
      c.drive_upper = -DRV_W'(10);
      c.drive_lower = DRV_W'(10);
      load_regs(c, 1'b0);
      push_sample(16'sd20, 16'sd0);
      push_sample(-16'sd20, 16'sd0);
      push_sample(16'sd0, 16'sd0);
      push_sample(-16'sd3000, 16'sd0);
      req_push <= 1'b0;
      drain();

      sent = 0;
      while (sent < 1550) begin
         n = $urandom_range(60, 200);
         load_regs(make_cfg(), bit'($urandom_range(0, 1)));
         if ($urandom_range(0, 3) == 0) begin
            write_csr(CSR_SPARE, CSR_W'($urandom));
            csr_we <= 1'b0;
         end
         pop_style <= pop_style_t'($urandom_range(0, 3));
         run_samples(n, sample_style_t'($urandom_range(0, 3)), bit'($urandom_range(0, 3) != 0));
         drain();
         sent += n;
      end

      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_drive.size() == 0)
         $display("pid_controller_fixed_point_top_test passed");
      else
         $display("pid_controller_fixed_point_top_test failed");
      $finish;
   end

endmodule
